// ===== hw/rtl/qrs_pkg.sv =====
// ----------------------------------------------------------------------------
// qrs_pkg
// shared types for the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DISC_NEG = 2'd1,
        ST_A_ZERO   = 2'd2,
        ST_SAT      = 2'd3
    } t_status;

endpackage

// ===== hw/rtl/qrs_sqrt.sv =====
// ----------------------------------------------------------------------------
// qrs_sqrt
// pipelined integer floor square root, one root bit per stage
// ----------------------------------------------------------------------------
module qrs_sqrt
    import qrs_pkg::*;
#(
    parameter int ROOT_W = 33
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [2*ROOT_W-1:0]   i_rad,
    output logic [ROOT_W-1:0]     o_root
);

    localparam int REM_W = ROOT_W + 1;

    logic [2*ROOT_W-1:0] w_rad  [0:ROOT_W];
    logic [REM_W-1:0]    w_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]   w_root [0:ROOT_W];
    logic [2*ROOT_W-1:0] r_rad  [0:ROOT_W-1];
    logic [REM_W-1:0]    r_rem  [0:ROOT_W-1];
    logic [ROOT_W-1:0]   r_root [0:ROOT_W-1];

    assign w_rad[0]  = i_rad;
    assign w_rem[0]  = '0;
    assign w_root[0] = '0;

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - k;
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic             ge;
        logic [REM_W+1:0] diff;

        assign rem_sh = {w_rem[k], w_rad[k][2*BIT+1 -: 2]};
        assign trial  = {1'b0, w_root[k], 2'b01};
        assign ge     = rem_sh >= trial;
        assign diff   = rem_sh - trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= w_rad[k];
                r_rem[k]  <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                r_root[k] <= {w_root[k][ROOT_W-2:0], ge};
            end
        end

        assign w_rad[k+1]  = r_rad[k];
        assign w_rem[k+1]  = r_rem[k];
        assign w_root[k+1] = r_root[k];
    end

    assign o_root = w_root[ROOT_W];

endmodule

// ===== hw/rtl/qrs_div.sv =====
// ----------------------------------------------------------------------------
// qrs_div
// pipelined restoring unsigned divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module qrs_div
    import qrs_pkg::*;
#(
    parameter int NUM_W = 50,
    parameter int DEN_W = 33
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic [NUM_W-1:0]  o_quo
);

    logic [NUM_W-1:0] w_num [0:NUM_W];
    logic [DEN_W-1:0] w_den [0:NUM_W];
    logic [DEN_W-1:0] w_rem [0:NUM_W];
    logic [NUM_W-1:0] w_quo [0:NUM_W];
    logic [NUM_W-1:0] r_num [0:NUM_W-1];
    logic [DEN_W-1:0] r_den [0:NUM_W-1];
    logic [DEN_W-1:0] r_rem [0:NUM_W-1];
    logic [NUM_W-1:0] r_quo [0:NUM_W-1];

    assign w_num[0] = i_num;
    assign w_den[0] = i_den;
    assign w_rem[0] = '0;
    assign w_quo[0] = '0;

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        localparam int BIT = NUM_W - 1 - k;
        logic [DEN_W:0] rem_sh;
        logic           ge;
        logic [DEN_W:0] diff;

        assign rem_sh = {w_rem[k], w_num[k][BIT]};
        assign ge     = rem_sh >= {1'b0, w_den[k]};
        assign diff   = rem_sh - {1'b0, w_den[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k] <= w_num[k];
                r_den[k] <= w_den[k];
                r_rem[k] <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
                r_quo[k] <= {w_quo[k][NUM_W-2:0], ge};
            end
        end

        assign w_num[k+1] = r_num[k];
        assign w_den[k+1] = r_den[k];
        assign w_rem[k+1] = r_rem[k];
        assign w_quo[k+1] = r_quo[k];
    end

    assign o_quo = w_quo[NUM_W];

endmodule

// ===== hw/rtl/quadratic_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_root_solver
// real roots of a*x^2 + b*x + c in signed fixed point
// throughput: one word per cycle unless i_stall holds the pipeline, set by the bit-per-stage sqrt and dividers
// the whole pipeline holds while a finished word waits on i_stall
// reset (synchronous, active low) clears all valid bits, data is not reset
// ----------------------------------------------------------------------------
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [DATA_WIDTH-1:0] i_coef_a,
    input  logic signed [DATA_WIDTH-1:0] i_coef_b,
    input  logic signed [DATA_WIDTH-1:0] i_coef_c,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_root_plus,
    output logic signed [DATA_WIDTH-1:0] o_root_minus,
    output logic        [1:0]            o_status
);

    localparam int W    = DATA_WIDTH;
    localparam int H    = (W + 1) / 2;      // half width for partial products
    localparam int RW   = W + 1;            // sqrt root width
    localparam int DW   = 2 * RW;           // discriminant width
    localparam int NW   = W + 2;            // numerator magnitude width
    localparam int QW   = NW + FRAC_BITS;   // dividend / quotient width
    localparam int SQ_SW = 2 * W + 4;       // side data through sqrt
    localparam int DV_SW = 5;               // side data through dividers
    localparam int L    = 6 + RW + QW;      // pipeline depth

    // global advance: hold everything while the output word is stalled
    logic         w_en;
    logic [L-1:0] r_vld;

    assign w_en    = !(r_vld[L-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    // stage 0: sign / magnitude split
    logic [W-1:0] r_ma, r_mb, r_mc;
    logic         r_an, r_bn, r_cn;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_an <= i_coef_a[W-1];
            r_bn <= i_coef_b[W-1];
            r_cn <= i_coef_c[W-1];
            r_ma <= i_coef_a[W-1] ? (~i_coef_a + 1'b1) : i_coef_a;
            r_mb <= i_coef_b[W-1] ? (~i_coef_b + 1'b1) : i_coef_b;
            r_mc <= i_coef_c[W-1] ? (~i_coef_c + 1'b1) : i_coef_c;
        end
    end

    // stage 1: half-width partial products of b*b and a*c
    logic [2*H-1:0] w_ma_x, w_mb_x, w_mc_x;
    logic [2*H-1:0] r_bb_ll, r_bb_lh, r_bb_hl, r_bb_hh;
    logic [2*H-1:0] r_ac_ll, r_ac_lh, r_ac_hl, r_ac_hh;
    logic [W-1:0]   r1_ma, r1_mb;
    logic           r1_an, r1_bn, r1_add, r1_az;

    assign w_ma_x = (2*H)'(r_ma);
    assign w_mb_x = (2*H)'(r_mb);
    assign w_mc_x = (2*H)'(r_mc);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bb_ll <= w_mb_x[H-1:0]   * w_mb_x[H-1:0];
            r_bb_lh <= w_mb_x[H-1:0]   * w_mb_x[2*H-1:H];
            r_bb_hl <= w_mb_x[2*H-1:H] * w_mb_x[H-1:0];
            r_bb_hh <= w_mb_x[2*H-1:H] * w_mb_x[2*H-1:H];
            r_ac_ll <= w_ma_x[H-1:0]   * w_mc_x[H-1:0];
            r_ac_lh <= w_ma_x[H-1:0]   * w_mc_x[2*H-1:H];
            r_ac_hl <= w_ma_x[2*H-1:H] * w_mc_x[H-1:0];
            r_ac_hh <= w_ma_x[2*H-1:H] * w_mc_x[2*H-1:H];
            r1_ma   <= r_ma;
            r1_mb   <= r_mb;
            r1_an   <= r_an;
            r1_bn   <= r_bn;
            // opposite signs with c nonzero: -4ac is positive
            r1_add  <= (r_an != r_cn) && (r_mc != '0);
            r1_az   <= (r_ma == '0);
        end
    end

    // stage 2: sum partials
    logic [4*H-1:0] w_bb_full, w_ac_full;
    logic [2*W-1:0] r_bb, r_ac;
    logic [W-1:0]   r2_ma, r2_mb;
    logic           r2_an, r2_bn, r2_add, r2_az;

    assign w_bb_full = ((4*H)'(r_bb_hh) << (2*H))
                     + (((4*H)'(r_bb_lh) + (4*H)'(r_bb_hl)) << H)
                     + (4*H)'(r_bb_ll);
    assign w_ac_full = ((4*H)'(r_ac_hh) << (2*H))
                     + (((4*H)'(r_ac_lh) + (4*H)'(r_ac_hl)) << H)
                     + (4*H)'(r_ac_ll);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bb   <= w_bb_full[2*W-1:0];
            r_ac   <= w_ac_full[2*W-1:0];
            r2_ma  <= r1_ma;
            r2_mb  <= r1_mb;
            r2_an  <= r1_an;
            r2_bn  <= r1_bn;
            r2_add <= r1_add;
            r2_az  <= r1_az;
        end
    end

    // stage 3: discriminant and early status
    logic [DW-1:0]    w_bb_x, w_ac4;
    logic [DW-1:0]    r_disc;
    t_status          w_st;
    logic [SQ_SW-1:0] r3_side;

    assign w_bb_x = DW'(r_bb);
    assign w_ac4  = {r_ac, 2'b00};

    always_comb begin
        if (r2_az) begin
            w_st = ST_A_ZERO;
        end else if (!r2_add && (w_ac4 > w_bb_x)) begin
            w_st = ST_DISC_NEG;
        end else begin
            w_st = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_disc  <= r2_add ? (w_bb_x + w_ac4) : (w_bb_x - w_ac4);
            r3_side <= {r2_mb, r2_bn, r2_ma, r2_an, w_st};
        end
    end

    // stages 4 .. 3+RW: square root, side data delayed alongside
    logic [RW-1:0]    w_root;
    logic [SQ_SW-1:0] r_sq_side [0:RW-1];

    qrs_sqrt #(
        .ROOT_W (RW)
    ) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_disc),
        .o_root (w_root)
    );

    for (genvar k = 0; k < RW; k++) begin : g_sq_side
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_side[k] <= (k == 0) ? r3_side : r_sq_side[(k == 0) ? 0 : k-1];
            end
        end
    end

    // numerator stage: -b +/- sqrt as sign and magnitude, zero is positive
    function automatic logic [NW:0] f_sadd(
        input logic          xn,
        input logic [NW-1:0] x,
        input logic          yn,
        input logic [NW-1:0] y
    );
        logic [NW-1:0] mag;
        logic          neg;
        if (xn == yn) begin
            mag = x + y;
            neg = xn;
        end else if (x >= y) begin
            mag = x - y;
            neg = xn;
        end else begin
            mag = y - x;
            neg = yn;
        end
        return {(mag != '0) && neg, mag};
    endfunction

    logic [W-1:0]     w_s_mb, w_s_ma;
    logic             w_s_bn, w_s_an;
    logic [1:0]       w_s_st;
    logic             w_xn;
    logic [NW:0]      w_np, w_nm;
    logic [NW-1:0]    r_nump, r_numm;
    logic [W:0]       r_den;
    logic [DV_SW-1:0] r_n_side;

    assign {w_s_mb, w_s_bn, w_s_ma, w_s_an, w_s_st} = r_sq_side[RW-1];
    assign w_xn = (w_s_mb != '0) && !w_s_bn;
    assign w_np = f_sadd(w_xn, NW'(w_s_mb), 1'b0, NW'(w_root));
    assign w_nm = f_sadd(w_xn, NW'(w_s_mb), 1'b1, NW'(w_root));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nump   <= w_np[NW-1:0];
            r_numm   <= w_nm[NW-1:0];
            r_den    <= {w_s_ma, 1'b0};
            r_n_side <= {w_np[NW], w_nm[NW], w_s_an, w_s_st};
        end
    end

    // divider stages: two roots in parallel, quotient truncated
    logic [QW-1:0]    w_qp, w_qm;
    logic [DV_SW-1:0] r_dv_side [0:QW-1];

    qrs_div #(
        .NUM_W (QW),
        .DEN_W (W + 1)
    ) u_div_plus (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({r_nump, {FRAC_BITS{1'b0}}}),
        .i_den (r_den),
        .o_quo (w_qp)
    );

    qrs_div #(
        .NUM_W (QW),
        .DEN_W (W + 1)
    ) u_div_minus (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num ({r_numm, {FRAC_BITS{1'b0}}}),
        .i_den (r_den),
        .o_quo (w_qm)
    );

    for (genvar k = 0; k < QW; k++) begin : g_dv_side
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_side[k] <= (k == 0) ? r_n_side : r_dv_side[(k == 0) ? 0 : k-1];
            end
        end
    end

    // final stage: sign, saturation and status
    logic         w_pn, w_mn, w_f_an;
    t_status      w_f_st;
    logic [W-1:0] w_rp, w_rm;
    logic         w_sp, w_sm;
    logic [W-1:0] r_rp, r_rm;
    t_status      r_st;

    assign w_pn   = r_dv_side[QW-1][4];
    assign w_mn   = r_dv_side[QW-1][3];
    assign w_f_an = r_dv_side[QW-1][2];
    assign w_f_st = t_status'(r_dv_side[QW-1][1:0]);

    function automatic logic [W:0] f_sat(input logic neg, input logic [QW-1:0] q);
        logic [QW-W:0] hi;
        logic          over;
        logic [W-1:0]  val;
        hi = q[QW-1:W-1];
        if (!neg) begin
            over = (hi != '0);
        end else begin
            over = (hi > (QW-W+1)'(1)) || ((hi == (QW-W+1)'(1)) && (q[W-2:0] != '0));
        end
        if (over) begin
            val = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            val = neg ? (~q[W-1:0] + 1'b1) : q[W-1:0];
        end
        return {over, val};
    endfunction

    assign {w_sp, w_rp} = f_sat(w_pn ^ w_f_an, w_qp);
    assign {w_sm, w_rm} = f_sat(w_mn ^ w_f_an, w_qm);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_f_st != ST_OK) begin
                r_rp <= '0;
                r_rm <= '0;
                r_st <= w_f_st;
            end else begin
                r_rp <= w_rp;
                r_rm <= w_rm;
                r_st <= (w_sp || w_sm) ? ST_SAT : ST_OK;
            end
        end
    end

    assign o_root_plus  = r_rp;
    assign o_root_minus = r_rm;
    assign o_status     = r_st;

    // checks
    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no word waiting");

    a_azero_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_A_ZERO)) |-> (o_root_plus == '0 && o_root_minus == '0))
        else $error("zero leading coefficient with nonzero roots");

    a_neg_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_DISC_NEG)) |-> (o_root_plus == '0 && o_root_minus == '0))
        else $error("negative discriminant with nonzero roots");

    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted word not in first stage");

endmodule
